### rtl/mtsl_pkg.sv
// ----------------------------------------------------------------------------
// mtsl_pkg
// Shared constants, types and helpers for the two-list merge block.
// ----------------------------------------------------------------------------
package mtsl_pkg;

    localparam int LIST_DEPTH    = 32;
    localparam int ELEMENT_WIDTH = 32;
    localparam int QUEUE_DEPTH   = 4;

    localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_LOAD_FIRST  = 2'd0,
        CMD_LOAD_SECOND = 2'd1,
        CMD_RUN         = 2'd2,
        CMD_NONE        = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_LOAD_FIRST,
        KIND_LOAD_SECOND,
        KIND_RUN
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic [ELEMENT_WIDTH-1:0] elem;
    } qent_t;

    // sign-extend (or truncate) a 32-bit input word to element width
    function automatic logic [ELEMENT_WIDTH-1:0] to_elem(input logic [31:0] v);
        logic [ELEMENT_WIDTH-1:0] e;
        for (int b = 0; b < ELEMENT_WIDTH; b++) begin
            e[b] = (b < 32) ? v[b] : v[31];
        end
        return e;
    endfunction

    // low 32 bits of an element, zero-filled above the element width
    function automatic logic [31:0] to_word(input logic [ELEMENT_WIDTH-1:0] e);
        logic [31:0] w;
        for (int b = 0; b < 32; b++) begin
            w[b] = (b < ELEMENT_WIDTH) ? e[b] : 1'b0;
        end
        return w;
    endfunction

endpackage

### rtl/mtsl_front.sv
// ----------------------------------------------------------------------------
// mtsl_front
// Input side: takes command words, classifies them and pushes them to the queue.
// ----------------------------------------------------------------------------
module mtsl_front (
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [31:0]            s_axis_tdata,   // [31:0] value
    input  logic [1:0]             s_axis_tuser,   // [1:0] cmd
    input  logic                   q_full,
    output logic                   q_push,
    output mtsl_pkg::qent_t        q_data
);

    mtsl_pkg::cmd_t cmd;

    assign cmd           = mtsl_pkg::cmd_t'(s_axis_tuser);
    assign s_axis_tready = !q_full;

    always_comb begin
        q_data.elem = mtsl_pkg::to_elem(s_axis_tdata);
        q_data.kind = mtsl_pkg::KIND_RUN;
        q_push      = 1'b0;
        case (cmd)
            mtsl_pkg::CMD_LOAD_FIRST: begin
                q_data.kind = mtsl_pkg::KIND_LOAD_FIRST;
                q_push      = s_axis_tvalid && !q_full;
            end
            mtsl_pkg::CMD_LOAD_SECOND: begin
                q_data.kind = mtsl_pkg::KIND_LOAD_SECOND;
                q_push      = s_axis_tvalid && !q_full;
            end
            mtsl_pkg::CMD_RUN: begin
                q_data.kind = mtsl_pkg::KIND_RUN;
                q_push      = s_axis_tvalid && !q_full;
            end
            default: begin
                // unused command: accepted and dropped
                q_push = 1'b0;
            end
        endcase
    end

endmodule

### rtl/mtsl_queue.sv
// ----------------------------------------------------------------------------
// mtsl_queue
// Short FIFO of classified commands between the front and back parts.
// ----------------------------------------------------------------------------
module mtsl_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  mtsl_pkg::qent_t        push_data,
    output logic                   full,
    input  logic                   pop,
    output logic                   not_empty,
    output mtsl_pkg::qent_t        pop_data
);

    mtsl_pkg::qent_t                    entry_reg [mtsl_pkg::QUEUE_DEPTH];
    logic [mtsl_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [mtsl_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [mtsl_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic                               do_push, do_pop;

    assign full      = (count_reg == mtsl_pkg::QCNT_W'(mtsl_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + mtsl_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + mtsl_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + mtsl_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - mtsl_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/mtsl_back.sv
// ----------------------------------------------------------------------------
// mtsl_back
// Back part: list RAMs, fill counts and the merge sequencer with output register.
// ----------------------------------------------------------------------------
module mtsl_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_not_empty,
    input  mtsl_pkg::qent_t        q_data,
    output logic                   q_pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [31:0]            m_axis_tdata,   // [31:0] merged_value
    output logic                   m_axis_tlast
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } state_t;

    localparam int EW = mtsl_pkg::ELEMENT_WIDTH;
    localparam int CW = mtsl_pkg::CNT_W;
    localparam int IW = mtsl_pkg::IDX_W;

    logic [EW-1:0] first_mem  [mtsl_pkg::LIST_DEPTH];
    logic [EW-1:0] second_mem [mtsl_pkg::LIST_DEPTH];

    state_t         state_reg, state_next;
    logic [CW-1:0]  cnt1_reg, cnt1_next;
    logic [CW-1:0]  cnt2_reg, cnt2_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [CW-1:0]  j_reg, j_next;
    logic           out_valid_reg, out_valid_next;
    logic [31:0]    out_data_reg, out_data_next;
    logic           out_last_reg, out_last_next;
    logic [EW-1:0]  rd1_reg, rd2_reg;

    logic           wr1, wr2;
    logic           out_free;
    logic           take_first;
    logic           i_done, j_done;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign i_done   = (i_reg == cnt1_reg);
    assign j_done   = (j_reg == cnt2_reg);
    assign take_first = j_done || (!i_done && ($signed(rd1_reg) <= $signed(rd2_reg)));

    always_comb begin
        state_next     = state_reg;
        cnt1_next      = cnt1_reg;
        cnt2_next      = cnt2_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        wr1            = 1'b0;
        wr2            = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (q_not_empty) begin
                    q_pop = 1'b1;
                    case (q_data.kind)
                        mtsl_pkg::KIND_LOAD_FIRST: begin
                            if (cnt1_reg != CW'(mtsl_pkg::LIST_DEPTH)) begin
                                wr1       = 1'b1;
                                cnt1_next = cnt1_reg + CW'(1);
                            end
                        end
                        mtsl_pkg::KIND_LOAD_SECOND: begin
                            if (cnt2_reg != CW'(mtsl_pkg::LIST_DEPTH)) begin
                                wr2       = 1'b1;
                                cnt2_next = cnt2_reg + CW'(1);
                            end
                        end
                        mtsl_pkg::KIND_RUN: begin
                            i_next = '0;
                            j_next = '0;
                            if (cnt1_reg != '0 || cnt2_reg != '0) begin
                                state_next = S_READ;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                // heads are being fetched from both RAMs
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (take_first) begin
                        out_data_next = mtsl_pkg::to_word(rd1_reg);
                        i_next        = i_reg + CW'(1);
                        out_last_next = (i_next == cnt1_reg) && j_done;
                    end else begin
                        out_data_next = mtsl_pkg::to_word(rd2_reg);
                        j_next        = j_reg + CW'(1);
                        out_last_next = i_done && (j_next == cnt2_reg);
                    end
                    if (out_last_next) begin
                        cnt1_next  = '0;
                        cnt2_next  = '0;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt1_reg      <= '0;
            cnt2_reg      <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt1_reg      <= cnt1_next;
            cnt2_reg      <= cnt2_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (wr1) begin
            first_mem[cnt1_reg[IW-1:0]] <= q_data.elem;
        end
        if (wr2) begin
            second_mem[cnt2_reg[IW-1:0]] <= q_data.elem;
        end
        rd1_reg <= first_mem[i_reg[IW-1:0]];
        rd2_reg <= second_mem[j_reg[IW-1:0]];
    end

endmodule

### rtl/merge_two_sorted_lists.sv
// ----------------------------------------------------------------------------
// merge_two_sorted_lists
// Loads two ascending lists of signed values and streams out their merge.
// ----------------------------------------------------------------------------
// Each input word carries a command in tuser and a value in tdata. Commands
// 0 and 1 append the value to the first or second list (up to 32 entries
// each; loads into a full list are dropped). Command 2 merges both lists
// and emits every element in ascending order, first list first on ties,
// with tlast on the final word; both lists are then empty. A merge of two
// empty lists emits nothing. Each merge step reads both list RAMs at the
// current heads into registers, then compares them and writes the output
// register; a step waits while the output register is still held.
// A four-word command queue lets input words keep arriving while a merge is
// in progress, until the queue fills; they are carried out after the merge ends.
module merge_two_sorted_lists (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] value
    input  logic [1:0]   s_axis_tuser,   // [1:0] cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // [31:0] merged_value
    output logic         m_axis_tlast
);

    logic             q_full;
    logic             q_push;
    mtsl_pkg::qent_t  q_push_data;
    logic             q_pop;
    logic             q_not_empty;
    mtsl_pkg::qent_t  q_pop_data;

    mtsl_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_push_data)
    );

    mtsl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_pop_data)
    );

    mtsl_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_not_empty   (q_not_empty),
        .q_data        (q_pop_data),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### tb/merge_two_sorted_lists_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// merge_two_sorted_lists_test
// Streams load and merge commands into the block and checks every merged word.
// ----------------------------------------------------------------------------
// A local model keeps both lists and predicts the words of each merge. Words
// out of the block are compared in order with the predicted ones. Stimulus
// is a short directed part (value extremes, ties, empty merge, unused
// command, an unsorted list), then random load sets that are mostly sorted,
// including two that overfill a list. Input idles in phases 2 and 4 of four,
// the receiver stalls in 3 and 4 and holds once, long, while loads come in.
// ----------------------------------------------------------------------------
module merge_two_sorted_lists_test;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef logic signed [mtsl_pkg::ELEMENT_WIDTH-1:0] elem_t;

    typedef struct {
        mtsl_pkg::cmd_t cmd;
        logic [31:0]    value;
    } cmd_word_t;

    typedef struct {
        logic [31:0] word;
        logic        last;
    } merged_word_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = mtsl_pkg::CMD_NONE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    cmd_word_t    cmd_words[$];
    merged_word_t merged_due[$];

    elem_t first_list [mtsl_pkg::LIST_DEPTH];
    elem_t second_list[mtsl_pkg::LIST_DEPTH];
    int    first_len  = 0;
    int    second_len = 0;

    int   total_words  = 1;
    int   words_in     = 0;
    int   phase        = 0;
    int   fail_count   = 0;
    int   quiet_cycles = 0;
    int   hold_left    = 0;
    bit   hold_used    = 1'b0;
    logic word_taken   = 1'b0;

    merge_two_sorted_lists DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 aclk = ~aclk;

    // list model: loads append, a merge emits both lists front to back
    function automatic void apply_command(input mtsl_pkg::cmd_t c, input logic [31:0] v);
        elem_t        e;
        int           i;
        int           j;
        merged_word_t r;
        e = elem_t'($signed(v));
        i = 0;
        j = 0;
        case (c)
            mtsl_pkg::CMD_LOAD_FIRST: begin
                if (first_len < mtsl_pkg::LIST_DEPTH) begin
                    first_list[first_len] = e;
                    first_len++;
                end
            end
            mtsl_pkg::CMD_LOAD_SECOND: begin
                if (second_len < mtsl_pkg::LIST_DEPTH) begin
                    second_list[second_len] = e;
                    second_len++;
                end
            end
            mtsl_pkg::CMD_RUN: begin
                while (i < first_len || j < second_len) begin
                    if (j >= second_len || (i < first_len && first_list[i] <= second_list[j])) begin
                        e = first_list[i];
                        i++;
                    end else begin
                        e = second_list[j];
                        j++;
                    end
                    r.word = 32'($unsigned(e));
                    r.last = (i == first_len && j == second_len);
                    merged_due.push_back(r);
                end
                first_len  = 0;
                second_len = 0;
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_value();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4) begin
            return $urandom;
        end else if (sel < 8) begin
            return int'($urandom_range(6)) - 3;
        end
        case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    function automatic int pick_len();
        if ($urandom_range(7) == 0) begin
            return $urandom_range(mtsl_pkg::LIST_DEPTH + 2);
        end
        return $urandom_range(6);
    endfunction

    task automatic add_word(input mtsl_pkg::cmd_t c, input logic [31:0] v);
        cmd_word_t w;
        w.cmd   = c;
        w.value = v;
        cmd_words.push_back(w);
    endtask

    // one load set: two lists, interleaved loads, then a merge
    task automatic add_merge_set(input int n1, input int n2, input bit sorted);
        int a[$];
        int b[$];
        a = {};
        b = {};
        repeat (n1) a.push_back(pick_value());
        repeat (n2) b.push_back(pick_value());
        if (sorted) begin
            a.sort();
            b.sort();
        end
        while (a.size() > 0 || b.size() > 0) begin
            if ($urandom_range(19) == 0) begin
                add_word(mtsl_pkg::CMD_NONE, $urandom);
            end
            if (b.size() == 0 || (a.size() > 0 && $urandom_range(1) == 0)) begin
                add_word(mtsl_pkg::CMD_LOAD_FIRST, a.pop_front());
            end else begin
                add_word(mtsl_pkg::CMD_LOAD_SECOND, b.pop_front());
            end
        end
        add_word(mtsl_pkg::CMD_RUN, $urandom);
    endtask

    initial begin
        int r;
        // empty merge and unused command
        add_word(mtsl_pkg::CMD_RUN, 32'h0000_0000);
        add_word(mtsl_pkg::CMD_NONE, 32'hFFFF_FFFF);
        // extremes and ties across both lists
        add_word(mtsl_pkg::CMD_LOAD_FIRST, 32'h8000_0000);
        add_word(mtsl_pkg::CMD_LOAD_FIRST, 32'hFFFF_FFFF);
        add_word(mtsl_pkg::CMD_LOAD_FIRST, 32'h0000_0000);
        add_word(mtsl_pkg::CMD_LOAD_FIRST, 32'h0000_0007);
        add_word(mtsl_pkg::CMD_LOAD_FIRST, 32'h7FFF_FFFF);
        add_word(mtsl_pkg::CMD_LOAD_SECOND, 32'h8000_0000);
        add_word(mtsl_pkg::CMD_LOAD_SECOND, 32'h0000_0000);
        add_word(mtsl_pkg::CMD_NONE, 32'h5555_5555);
        add_word(mtsl_pkg::CMD_LOAD_SECOND, 32'h0000_0007);
        add_word(mtsl_pkg::CMD_LOAD_SECOND, 32'h7FFF_FFFF);
        add_word(mtsl_pkg::CMD_RUN, 32'hAAAA_AAAA);
        // single word from either list
        add_word(mtsl_pkg::CMD_LOAD_FIRST, 32'h0000_0005);
        add_word(mtsl_pkg::CMD_RUN, 32'h0000_0000);
        add_word(mtsl_pkg::CMD_LOAD_SECOND, 32'hFFFF_FFFB);
        add_word(mtsl_pkg::CMD_RUN, 32'h0000_0000);
        // unsorted first list
        add_word(mtsl_pkg::CMD_LOAD_FIRST, 32'h0000_0003);
        add_word(mtsl_pkg::CMD_LOAD_FIRST, 32'h0000_0001);
        add_word(mtsl_pkg::CMD_LOAD_SECOND, 32'h0000_0002);
        add_word(mtsl_pkg::CMD_RUN, 32'h0000_0000);

        // full lists: extra loads are dropped
        add_merge_set(mtsl_pkg::LIST_DEPTH + 2, 2, 1'b1);
        add_merge_set(0, mtsl_pkg::LIST_DEPTH + 3, 1'b1);
        while (cmd_words.size() < 165) begin
            r = $urandom_range(9);
            if (r == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    add_word(mtsl_pkg::cmd_t'($urandom_range(3)), $urandom);
                end
            end else begin
                add_merge_set(pick_len(), pick_len(), r != 1);
            end
        end
        total_words = cmd_words.size();

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        while (cmd_words.size() > 0 || s_axis_tvalid || merged_due.size() > 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("merge_two_sorted_lists test passed");
        end else begin
            $display("merge_two_sorted_lists test failed");
        end
        $finish;
    end

    // driver
    always @(negedge aclk) begin : drive
        cmd_word_t w;
        int        idle_pct;
        idle_pct = (phase == 1) ? 69 : (phase == 3) ? 33 : 0;
        if (aresetn && (!s_axis_tvalid || word_taken)) begin
            if (cmd_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
                w = cmd_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= w.value;
                s_axis_tuser  <= w.cmd;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold while a merge is in flight
    always @(negedge aclk) begin : receive
        int stall_pct;
        stall_pct = (phase == 2) ? 69 : (phase == 3) ? 33 : 0;
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_used && words_in >= 25 && merged_due.size() > 0) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor and checker
    always @(posedge aclk) begin : check
        merged_word_t due;
        if (!aresetn) begin
            word_taken <= 1'b0;
        end else begin
            word_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                apply_command(mtsl_pkg::cmd_t'(s_axis_tuser), s_axis_tdata);
                words_in <= words_in + 1;
                phase    <= ((words_in + 1) * 4 / total_words > 3) ? 3
                                                                   : (words_in + 1) * 4 / total_words;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (merged_due.size() == 0) begin
                    $error("unexpected word: merged_value %0d last_item %0b",
                           $signed(m_axis_tdata), m_axis_tlast);
                    fail_count++;
                end else begin
                    due = merged_due.pop_front();
                    if (m_axis_tdata !== due.word) begin
                        $error("merged_value: expected %0d, got %0d",
                               $signed(due.word), $signed(m_axis_tdata));
                        fail_count++;
                    end
                    if (m_axis_tlast !== due.last) begin
                        $error("last_item: expected %0b, got %0b", due.last, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("merge_two_sorted_lists test failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule

### files.f
rtl/mtsl_pkg.sv
rtl/mtsl_front.sv
rtl/mtsl_queue.sv
rtl/mtsl_back.sv
rtl/merge_two_sorted_lists.sv
tb/merge_two_sorted_lists_test.sv
